@@ design/rlms_pkg.sv @@
`default_nettype none

package rlms_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned LEVEL_W     = 7;
  localparam int unsigned SCALE_BITS  = 19;
  localparam int unsigned SQ_SHIFT    = 2 * (SAMPLE_BITS - 1);

  // 300^2 * 4, the (2t-1)^2 test folds the factor four in
  localparam logic [SCALE_BITS-1:0] RMS_SCALE  = 19'd360000;
  localparam logic [LEVEL_W-1:0]    TARGET_MAX = 7'd100;
  localparam logic [LEVEL_W-1:0]    LEVEL_MAX  = 7'd100;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_of_block;
  } in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               block_truncated;
  } out_t;

  typedef struct packed {
    logic accum;
    logic close_blk;
    logic mul_step;
    logic srch_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_last;
    logic srch_last;
  } stat_t;

  typedef enum logic [3:0] {
    ST_ACCUM  = 4'b0001,
    ST_MUL    = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

endpackage

`default_nettype wire

@@ design/rms_level_meter_smoothed_top.sv @@
// samples: one beat per cycle while a block accumulates
// final beat of a block: in_ready_o drops for a 19-step scale
//   multiply plus a 1..100 step target search and the smoothing update,
//   longer while a result beat waits for out_ready_i
// result is loaded into the output register after the search, once no pending result beat is left
// reset clears the accumulator, the smoothed level and the output valid
`default_nettype none

module rms_level_meter_smoothed_top #(
  parameter int unsigned MAX_BLOCK_SAMPLES   = 4096,
  parameter int unsigned LEVEL_FRACTION_BITS = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rlms_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rlms_pkg::out_t     out_data_o
);
  import rlms_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rlms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_of_block),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rlms_datapath #(
    .MAX_BLOCK_SAMPLES   (MAX_BLOCK_SAMPLES),
    .LEVEL_FRACTION_BITS (LEVEL_FRACTION_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

@@ design/rlms_ctrl.sv @@
`default_nettype none

module rlms_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_last_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire rlms_pkg::stat_t stat_i,
  output rlms_pkg::cmd_t     cmd_o
);
  import rlms_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_load;

  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_ACCUM: begin
        in_ready_o      = 1'b1;
        cmd_o.accum     = in_valid_i;
        cmd_o.close_blk = in_valid_i && in_last_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (stat_i.mul_last) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.srch_step = 1'b1;
        if (stat_i.srch_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (can_load) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ design/rlms_datapath.sv @@
`default_nettype none

module rlms_datapath #(
  parameter int unsigned MAX_BLOCK_SAMPLES   = 4096,
  parameter int unsigned LEVEL_FRACTION_BITS = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rlms_pkg::in_t   in_data_i,
  input  wire rlms_pkg::cmd_t  cmd_i,
  output rlms_pkg::stat_t      stat_o,
  output rlms_pkg::out_t       out_data_o
);
  import rlms_pkg::*;

  localparam int unsigned F      = LEVEL_FRACTION_BITS;
  localparam int unsigned CNT_W  = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int unsigned SUM_W  = SQ_SHIFT + CNT_W;
  localparam int unsigned PROD_W = SUM_W + SCALE_BITS;
  localparam int unsigned RS_W   = PROD_W - SQ_SHIFT;
  localparam int unsigned L_W    = CNT_W + 16;
  localparam int unsigned D_W    = CNT_W + 10;
  localparam int unsigned K_W    = $clog2(SCALE_BITS);
  localparam int unsigned SM_W   = LEVEL_W + F;
  localparam int unsigned MIX_W  = SM_W + 2;
  localparam int unsigned RND_W  = SM_W + 1;
  localparam int unsigned LR_W   = RND_W - F;
  localparam logic [CNT_W-1:0] MAX_C  = CNT_W'(MAX_BLOCK_SAMPLES);
  localparam logic [K_W-1:0]   K_LAST = K_W'(SCALE_BITS - 1);

  // block accumulation
  logic [SUM_W-1:0] acc_sum_q;
  logic [CNT_W-1:0] acc_cnt_q;
  logic             acc_ovf_q;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [2*SAMPLE_BITS-1:0] sq;
  logic             room;
  logic [SUM_W-1:0] sum_nx;
  logic [CNT_W-1:0] cnt_nx;
  logic             ovf_nx;

  // scale multiply and target search
  logic [PROD_W-1:0] msh_q, prod_q;
  logic [K_W-1:0]    k_q;
  logic [CNT_W-1:0]  blk_cnt_q;
  logic              blk_ovf_q;
  logic [L_W-1:0]    l_q;
  logic [D_W-1:0]    d_q;
  logic [LEVEL_W-1:0] t_q, best_q;
  logic [RS_W-1:0]   rs;
  logic              hit;

  // smoothing
  logic [SM_W-1:0]    sm_q, sm_d;
  logic [MIX_W-1:0]   mix;
  logic [RND_W-1:0]   rnd;
  logic [LR_W-1:0]    lvl_raw;
  logic [LEVEL_W-1:0] lvl;
  out_t               out_q;

  always_comb begin
    mag    = in_data_i.sample[SAMPLE_BITS-1] ? (~in_data_i.sample + 1'b1) : in_data_i.sample;
    sq     = mag * mag;
    room   = acc_cnt_q < MAX_C;
    sum_nx = acc_sum_q + (room ? SUM_W'(sq) : '0);
    cnt_nx = acc_cnt_q + (room ? CNT_W'(1) : '0);
    ovf_nx = acc_ovf_q | ~room;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_sum_q <= '0;
      acc_cnt_q <= '0;
      acc_ovf_q <= 1'b0;
    end else if (cmd_i.accum) begin
      if (cmd_i.close_blk) begin
        acc_sum_q <= '0;
        acc_cnt_q <= '0;
        acc_ovf_q <= 1'b0;
      end else begin
        acc_sum_q <= sum_nx;
        acc_cnt_q <= cnt_nx;
        acc_ovf_q <= ovf_nx;
      end
    end
  end

  assign rs  = prod_q[PROD_W-1:SQ_SHIFT];
  assign hit = (blk_cnt_q != '0) && (RS_W'(l_q) <= rs);

  assign stat_o.mul_last  = (k_q == K_LAST);
  assign stat_o.srch_last = !hit || (t_q == TARGET_MAX);

  always_ff @(posedge clk_i) begin
    if (cmd_i.close_blk) begin
      msh_q     <= PROD_W'(sum_nx);
      prod_q    <= '0;
      k_q       <= '0;
      blk_cnt_q <= cnt_nx;
      blk_ovf_q <= ovf_nx;
      l_q       <= L_W'(cnt_nx);
      d_q       <= D_W'({cnt_nx, 3'b000});
      t_q       <= LEVEL_W'(1);
      best_q    <= '0;
    end else if (cmd_i.mul_step) begin
      if (RMS_SCALE[k_q]) begin
        prod_q <= prod_q + msh_q;
      end
      msh_q <= msh_q << 1;
      k_q   <= k_q + 1'b1;
    end else if (cmd_i.srch_step && hit) begin
      best_q <= t_q;
      t_q    <= t_q + 1'b1;
      l_q    <= l_q + L_W'(d_q);
      d_q    <= d_q + D_W'({blk_cnt_q, 3'b000});
    end
  end

  always_comb begin
    mix     = MIX_W'(sm_q) + MIX_W'({sm_q, 1'b0}) + (MIX_W'(best_q) << F) + MIX_W'(2);
    sm_d    = mix[MIX_W-1:2];
    rnd     = RND_W'(sm_d) + (RND_W'(1) << (F - 1));
    lvl_raw = rnd[RND_W-1:F];
    lvl     = (lvl_raw > LR_W'(LEVEL_MAX)) ? LEVEL_MAX : lvl_raw[LEVEL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_q <= '0;
    end else if (cmd_i.out_load) begin
      sm_q <= sm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.level           <= lvl;
      out_q.block_truncated <= blk_ovf_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

@@ design/rlms_checker.sv @@
`default_nettype none

module rlms_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire rlms_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire rlms_pkg::out_t out_data_o
);
  import rlms_pkg::*;

  // a pending result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // the final beat of a block starts the level computation
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_of_block |=> !in_ready_o)
    else $error("input still ready after final beat");

  // input stalls only after a final beat
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && in_data_i.last_of_block))
    else $error("input stalled without a final beat");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.level <= LEVEL_MAX)
    else $error("level above full scale");

endmodule

bind rms_level_meter_smoothed_top rlms_checker u_rlms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
